// File: hw/rtl/h3dfr_pkg.sv
// Shared types and constants for the HTTP/3 frame deframer.
// No dependencies; used by the varint gatherer, the parse stage and the top level.
package h3dfr_pkg;

    localparam int BYTE_W  = 8;
    localparam int VAL_W   = 62;
    localparam int LEFT_W  = 3;
    localparam int PFX_LSB = 6;

    localparam logic [BYTE_W-1:0] VAL_MASK = 8'h3F;

    // Length prefix of a varint's first byte, from bits [7:6]
    localparam logic [1:0] PFX_1B = 2'd0;
    localparam logic [1:0] PFX_2B = 2'd1;
    localparam logic [1:0] PFX_4B = 2'd2;
    localparam logic [1:0] PFX_8B = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              byte_valid;
        logic              is_header;
        logic              frame_end;
        logic              buffer_end;
        logic              truncated;
    } result_t;

endpackage

// File: hw/rtl/h3dfr_varint.sv
// Variable-length integer gatherer: folds one byte into the value being built.
// Depends on h3dfr_pkg.
module h3dfr_varint
(
    input  logic [h3dfr_pkg::BYTE_W-1:0] data_byte,
    input  logic [h3dfr_pkg::VAL_W-1:0]  accum,
    input  logic [h3dfr_pkg::LEFT_W-1:0] bytes_left,
    output logic [h3dfr_pkg::VAL_W-1:0]  new_accum,
    output logic [h3dfr_pkg::LEFT_W-1:0] new_left,
    output logic                         done
);

    logic [h3dfr_pkg::LEFT_W-1:0] first_left;

    always_comb
    begin
        unique case (data_byte[h3dfr_pkg::BYTE_W-1:h3dfr_pkg::PFX_LSB])
            h3dfr_pkg::PFX_1B: first_left = 3'd0;
            h3dfr_pkg::PFX_2B: first_left = 3'd1;
            h3dfr_pkg::PFX_4B: first_left = 3'd3;
            h3dfr_pkg::PFX_8B: first_left = 3'd7;
            default:           first_left = 3'd0;
        endcase
    end

    always_comb
    begin
        if (bytes_left == '0)
        begin
            // first byte: keep the low six bits, take the size from the prefix
            new_accum = {{(h3dfr_pkg::VAL_W-h3dfr_pkg::BYTE_W){1'b0}},
                         data_byte & h3dfr_pkg::VAL_MASK};
            new_left  = first_left;
        end
        else
        begin
            new_accum = {accum[h3dfr_pkg::VAL_W-h3dfr_pkg::BYTE_W-1:0], data_byte};
            new_left  = bytes_left - 3'd1;
        end
        done = (new_left == '0);
    end

endmodule

// File: hw/rtl/h3dfr_parse.sv
// Frame parse stage: holds the parser state and turns one byte into at most one result.
// Depends on h3dfr_pkg and h3dfr_varint.
module h3dfr_parse
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [h3dfr_pkg::BYTE_W-1:0]  in_byte,
    input  logic                          in_last,
    output logic                          res_emit,
    output h3dfr_pkg::result_t            res
);

    localparam logic [1:0] PH_TYPE    = 2'd0;
    localparam logic [1:0] PH_LEN     = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;

    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_HEADERS = 2'd1;
    localparam logic [1:0] KIND_OTHER   = 2'd2;

    logic [1:0]                   phase_reg, phase_next;
    logic [h3dfr_pkg::VAL_W-1:0]  accum_reg, accum_next;
    logic [h3dfr_pkg::LEFT_W-1:0] left_reg, left_next;
    logic [1:0]                   kind_reg, kind_next;
    logic [h3dfr_pkg::VAL_W-1:0]  pl_reg, pl_next;

    logic [h3dfr_pkg::VAL_W-1:0]  vi_accum;
    logic [h3dfr_pkg::LEFT_W-1:0] vi_left;
    logic                         vi_done;
    logic [h3dfr_pkg::VAL_W-1:0]  pl_dec;
    logic                         pay_valid;
    logic                         pay_hdr;
    logic                         pay_end;
    logic                         clean_end;

    h3dfr_varint u_varint
    (
        .data_byte  (in_byte),
        .accum      (accum_reg),
        .bytes_left (left_reg),
        .new_accum  (vi_accum),
        .new_left   (vi_left),
        .done       (vi_done)
    );

    assign pl_dec = pl_reg - {{(h3dfr_pkg::VAL_W-1){1'b0}}, 1'b1};

    always_comb
    begin
        phase_next = phase_reg;
        accum_next = accum_reg;
        left_next  = left_reg;
        kind_next  = kind_reg;
        pl_next    = pl_reg;
        pay_valid  = 1'b0;
        pay_hdr    = 1'b0;
        pay_end    = 1'b0;

        unique case (phase_reg)
            PH_LEN:
            begin
                accum_next = vi_accum;
                left_next  = vi_left;
                if (vi_done)
                begin
                    pl_next    = vi_accum;
                    phase_next = (vi_accum == '0) ? PH_TYPE : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                pl_next = pl_dec;
                if (kind_reg == KIND_DATA || kind_reg == KIND_HEADERS)
                begin
                    pay_valid = 1'b1;
                    pay_hdr   = (kind_reg == KIND_HEADERS);
                    pay_end   = (pl_dec == '0);
                end
                if (pl_dec == '0)
                    phase_next = PH_TYPE;
            end
            default:
            begin
                // frame type; the unused phase code lands here as well
                accum_next = vi_accum;
                left_next  = vi_left;
                if (vi_done)
                begin
                    if (vi_accum == '0)
                        kind_next = KIND_DATA;
                    else if (vi_accum == {{(h3dfr_pkg::VAL_W-1){1'b0}}, 1'b1})
                        kind_next = KIND_HEADERS;
                    else
                        kind_next = KIND_OTHER;
                    phase_next = PH_LEN;
                end
                else
                    phase_next = PH_TYPE;
            end
        endcase

        clean_end = (phase_next == PH_TYPE) && (left_next == '0);

        // drop all state at the end of a buffer
        if (in_last)
        begin
            phase_next = PH_TYPE;
            accum_next = '0;
            left_next  = '0;
            kind_next  = KIND_DATA;
            pl_next    = '0;
        end
    end

    always_comb
    begin
        res_emit         = step && (pay_valid || in_last);
        res.payload_byte = pay_valid ? in_byte : '0;
        res.byte_valid   = pay_valid;
        res.is_header    = pay_hdr;
        res.frame_end    = pay_end;
        res.buffer_end   = in_last;
        res.truncated    = in_last && !clean_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TYPE;
            accum_reg <= '0;
            left_reg  <= '0;
            kind_reg  <= KIND_DATA;
            pl_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            accum_reg <= accum_next;
            left_reg  <= left_next;
            kind_reg  <= kind_next;
            pl_reg    <= pl_next;
        end
    end

    a_trunc_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_emit && res.truncated |-> res.buffer_end)
        else $error("truncated raised without buffer end");

    a_fend_valid: assert property (@(posedge clk) disable iff (!rst_n)
        res_emit && (res.frame_end || res.is_header) |-> res.byte_valid)
        else $error("frame flags without a payload byte");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && in_last |=> phase_reg == PH_TYPE && left_reg == '0 && pl_reg == '0)
        else $error("parser state not cleared after buffer end");

    a_left_in_varint: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg != '0 |-> phase_reg == PH_TYPE || phase_reg == PH_LEN)
        else $error("varint bytes owed outside a varint phase");

endmodule

// File: hw/rtl/http3_frame_deframer.sv
// HTTP/3 frame deframer, top level: input register, parse stage, output register.
// Depends on h3dfr_pkg and h3dfr_parse.
//
// Use: feed the raw bytes of a stream buffer on the s_axis channel, one byte per
// transaction, with s_axis_tlast on the final byte of the buffer. Each frame is a
// varint type, a varint length and the payload. DATA and HEADERS payload bytes
// come out on m_axis, one byte per transaction, tagged in tuser; payload of other
// frame types is skipped and yields nothing. The byte marked last always yields a
// result with m_axis_tlast set, carrying truncated if the buffer stopped inside a
// frame, and the parser then starts afresh for the next buffer.
// Throughput: one byte per cycle while m_axis is not stalled (see Stall), set by
// the state update in the parse stage. A byte is taken into the input register,
// then parsed from there into the output register, which presents it on m_axis.
// Reset: all parser state returns to "reading frame type", both registers empty.
// Stall: while m_axis_tready is low the result is held; the input register
// still empties on bytes that give no result, and s_axis_tready drops only
// when a held byte needs the occupied output register.
module http3_frame_deframer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
    input  logic        s_axis_tlast,   // buffer_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [8] frame_end, [9] truncated
    output logic [1:0]  m_axis_tuser,   // [0] byte_valid, [1] is_header
    output logic        m_axis_tlast    // buffer_end
);

    logic                         in_valid_reg;
    logic [h3dfr_pkg::BYTE_W-1:0] in_byte_reg;
    logic                         in_last_reg;
    logic                         out_valid_reg;
    h3dfr_pkg::result_t           out_res_reg;

    logic                         out_free;
    logic                         step;
    logic                         res_emit;
    h3dfr_pkg::result_t           res;
    // a byte needs the output register only if it gives a result
    logic                         res_emit_need;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && (out_free || !(res_emit_need));
    assign s_axis_tready = !in_valid_reg || step;

    h3dfr_parse u_parse
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .in_byte  (in_byte_reg),
        .in_last  (in_last_reg),
        .res_emit (res_emit),
        .res      (res)
    );

    assign res_emit_need = res.byte_valid || in_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_emit)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_emit)
            out_res_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_res_reg.truncated, out_res_reg.frame_end,
                            out_res_reg.payload_byte};
    assign m_axis_tuser  = {out_res_reg.is_header, out_res_reg.byte_valid};
    assign m_axis_tlast  = out_res_reg.buffer_end;

endmodule
